### rtl/core/rgbf_pkg.sv
// Package for the RGB LED PWM mode fader: register, state and result types,
// mode codes, register indexes and reset values. No dependencies.
`default_nettype none

package rgbf_pkg;

  // mode codes
  localparam logic [1:0] MODE_RAINBOW = 2'd0;
  localparam logic [1:0] MODE_RED     = 2'd1;
  localparam logic [1:0] MODE_GREEN   = 2'd2;
  localparam logic [1:0] MODE_BLUE    = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_PWM_PERIOD   = 2'd0;
  localparam logic [1:0] REG_LONG_PRESS   = 2'd1;
  localparam logic [1:0] REG_TICKS_PER_MS = 2'd2;
  localparam logic [1:0] REG_CONFIRM      = 2'd3;

  localparam int CFG_W = 24;

  // reset values
  localparam logic [7:0]  RST_PWM_PERIOD   = 8'd80;
  localparam logic [15:0] RST_LONG_PRESS   = 16'd6000;
  localparam logic [7:0]  RST_TICKS_PER_MS = 8'd38;
  localparam logic [23:0] RST_CONFIRM      = 24'd75000;

  typedef struct packed {
    logic [7:0]  pwm_period;
    logic [15:0] long_press_ticks;
    logic [7:0]  ticks_per_ms;
    logic [23:0] confirm_ticks;
  } rgbf_cfg_t;

  typedef struct packed {
    logic [7:0]  red_level;
    logic [7:0]  green_level;
    logic [7:0]  blue_level;
    logic [7:0]  pwm_count;
    logic [15:0] held_count;
    logic [1:0]  mode;
    logic [23:0] confirm_left;
    logic [15:0] fade_wait;
  } rgbf_state_t;

  typedef struct packed {
    logic [1:0] mode_now;
    logic       blue_on;
    logic       green_on;
    logic       red_on;
  } rgbf_result_t;

endpackage

`default_nettype wire

### rtl/core/rgb_led_pwm_mode_fader_core.sv
// Top level of the RGB LED PWM mode fader: stream ports, configuration
// registers, tick state and result register. Depends on rgbf_pkg, rgbf_step.
`default_nettype none

// Usage
//   Each item on the s_ side is one PWM timer tick: button level and speed.
//   Each tick yields exactly one item on the m_ side: three LED enables and
//   the current mode. A channel is lit when its color level exceeds the
//   wrapping PWM count; all are dark while the button is held.
//   Configuration (pwm_period, long_press_ticks, ticks_per_ms, confirm_ticks)
//   is written through cfg_we/cfg_index/cfg_data, one register per cycle,
//   while the stream is idle.
// Timing
//   A tick accepted at an edge shows on m_tdata with m_tvalid right after it.
//   One item per cycle is sustained while the receiver does not stall; the whole
//   tick update (PWM wrap, fade rules, press counting, confirm timer) is one
//   pass of logic into the state and result registers.
// Reset
//   rst (synchronous) loads the register defaults, green mode, green level
//   at full, all counters zero, and empties the result register.
// Stall
//   s_tready is high while the result register is empty or being taken; when
//   the receiver stalls, the result holds and no new tick is taken.

module rgb_led_pwm_mode_fader_core import rgbf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  // input ticks
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [15:0]      s_tdata,   // [0] button_pressed, [8:1] speed, rest zero
  // results
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,   // [0] red_on, [1] green_on, [2] blue_on,
                                      // [4:3] mode_now, rest zero
  // configuration writes
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  rgbf_cfg_t    cfg;
  rgbf_state_t  st;
  rgbf_state_t  st_next;
  rgbf_result_t res_next;
  rgbf_result_t res;
  logic         accept;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pwm_period       <= RST_PWM_PERIOD;
      cfg.long_press_ticks <= RST_LONG_PRESS;
      cfg.ticks_per_ms     <= RST_TICKS_PER_MS;
      cfg.confirm_ticks    <= RST_CONFIRM;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PWM_PERIOD:   cfg.pwm_period       <= cfg_data[7:0];
        REG_LONG_PRESS:   cfg.long_press_ticks <= cfg_data[15:0];
        REG_TICKS_PER_MS: cfg.ticks_per_ms     <= cfg_data[7:0];
        REG_CONFIRM:      cfg.confirm_ticks    <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  rgbf_step u_step (
    .cfg            (cfg),
    .st             (st),
    .button_pressed (s_tdata[0]),
    .speed          (s_tdata[8:1]),
    .st_next        (st_next),
    .res            (res_next)
  );

  // tick state, advanced once per accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      st.red_level    <= 8'd0;
      st.green_level  <= RST_PWM_PERIOD;
      st.blue_level   <= 8'd0;
      st.pwm_count    <= 8'd0;
      st.held_count   <= 16'd0;
      st.mode         <= MODE_GREEN;
      st.confirm_left <= 24'd0;
      st.fade_wait    <= 16'd0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) res <= res_next;
  end

  assign m_tdata = {3'b000, res.mode_now, res.blue_on, res.green_on, res.red_on};

  // an accepted tick always leaves a result behind
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted tick produced no result");

  // mode only moves on an accepted tick
  a_mode_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> st.mode == $past(st.mode))
    else $error("mode changed without a tick");

  // a release always clears the held counter
  a_release_clears_held: assert property (@(posedge clk) disable iff (rst)
    (accept && !s_tdata[0]) |=> st.held_count == 16'd0)
    else $error("held count survived a release");

  // red is dark when its level does not exceed the count
  a_red_off: assert property (@(posedge clk) disable iff (rst)
    (accept && !(st.red_level > st.pwm_count)) |=> !m_tdata[0])
    else $error("red lit below its level");

endmodule

`default_nettype wire

### rtl/core/rgbf_step.sv
// Next-state and LED drive logic for one PWM tick of the mode fader.
// Depends on rgbf_pkg.
`default_nettype none

module rgbf_step import rgbf_pkg::*; (
  input  rgbf_cfg_t    cfg,
  input  rgbf_state_t  st,
  input  logic         button_pressed,
  input  logic [7:0]   speed,
  output rgbf_state_t  st_next,
  output rgbf_result_t res
);

  // advance mode; entering rainbow restarts the fade from red
  function automatic rgbf_state_t step_mode(rgbf_state_t s, logic [7:0] top);
    rgbf_state_t o;
    o      = s;
    o.mode = s.mode + 2'd1;
    if (o.mode == MODE_RAINBOW) begin
      o.red_level   = top;
      o.green_level = 8'd0;
      o.blue_level  = 8'd0;
      o.fade_wait   = 16'd0;
    end
    return o;
  endfunction

  // six ordered fade rules, each sees the result of the previous one
  function automatic rgbf_state_t fade_once(rgbf_state_t s, logic [7:0] top);
    rgbf_state_t o;
    o = s;
    if (o.blue_level != 8'd0 && o.red_level == top && o.green_level == 8'd0)
      o.blue_level = o.blue_level - 8'd1;
    if (o.blue_level == top && o.red_level < top && o.green_level == 8'd0)
      o.red_level = o.red_level + 8'd1;
    if (o.green_level != 8'd0 && o.blue_level == top && o.red_level == 8'd0)
      o.green_level = o.green_level - 8'd1;
    if (o.green_level == top && o.blue_level < top && o.red_level == 8'd0)
      o.blue_level = o.blue_level + 8'd1;
    if (o.red_level != 8'd0 && o.green_level == top && o.blue_level == 8'd0)
      o.red_level = o.red_level - 8'd1;
    if (o.red_level == top && o.green_level < top && o.blue_level == 8'd0)
      o.green_level = o.green_level + 8'd1;
    return o;
  endfunction

  always_comb begin
    rgbf_state_t s;
    logic [7:0]  top;
    logic [7:0]  cnt_inc;
    logic [15:0] interval;

    top      = cfg.pwm_period;
    interval = 16'(speed) * 16'(cfg.ticks_per_ms);

    res.red_on   = !button_pressed && (st.red_level > st.pwm_count);
    res.green_on = !button_pressed && (st.green_level > st.pwm_count);
    res.blue_on  = !button_pressed && (st.blue_level > st.pwm_count);
    res.mode_now = st.mode;

    s       = st;
    cnt_inc = st.pwm_count + 8'd1;
    s.pwm_count = (cnt_inc >= top) ? 8'd0 : cnt_inc;

    if (st.confirm_left != 24'd0) begin
      // yellow while confirming
      s.red_level    = top;
      s.green_level  = top;
      s.blue_level   = 8'd0;
      s.confirm_left = st.confirm_left - 24'd1;
      if (s.confirm_left == 24'd0) s = step_mode(s, top);
    end else begin
      unique case (st.mode)
        MODE_RED: begin
          s.red_level   = top;
          s.green_level = 8'd0;
          s.blue_level  = 8'd0;
        end
        MODE_GREEN: begin
          s.red_level   = 8'd0;
          s.green_level = top;
          s.blue_level  = 8'd0;
        end
        MODE_BLUE: begin
          s.red_level   = top;
          s.green_level = top;
          s.blue_level  = top;
        end
        default: begin
          if (st.fade_wait == 16'd0) begin
            s           = fade_once(s, top);
            s.fade_wait = (interval != 16'd0) ? interval - 16'd1 : 16'd0;
          end else begin
            s.fade_wait = st.fade_wait - 16'd1;
          end
        end
      endcase
    end

    if (button_pressed) begin
      if (st.held_count != 16'hFFFF) s.held_count = st.held_count + 16'd1;
    end else begin
      if (st.held_count > cfg.long_press_ticks && s.confirm_left == 24'd0) begin
        if (cfg.confirm_ticks == 24'd0) begin
          s = step_mode(s, top);
        end else begin
          s.confirm_left = cfg.confirm_ticks;
          s.red_level    = top;
          s.green_level  = top;
          s.blue_level   = 8'd0;
        end
      end
      s.held_count = 16'd0;
    end

    st_next = s;
  end

endmodule

`default_nettype wire
